// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/steq_pkg.sv -----
// types and codes of the stable time-ordered event queue
`default_nettype none

package steq_pkg;

    // request codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // input transfer
    typedef struct packed {
        logic        mode;
        logic [31:0] event_time;
        logic [7:0]  event_kind;
        logic [15:0] first_datum;
        logic [15:0] second_datum;
    } t_in;

    // output transfer
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_time;
        logic [7:0]  out_kind;
        logic [15:0] out_first;
        logic [15:0] out_second;
        logic        is_empty;
        logic [4:0]  occupancy;
    } t_out;

    // one stored event
    typedef struct packed {
        logic [31:0] ev_time;
        logic [7:0]  ev_kind;
        logic [15:0] ev_first;
        logic [15:0] ev_second;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/steq_cell.sv -----
// one slot of the shift-register queue with its own time compare
`default_nettype none

module steq_cell
    import steq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_new,
    input  wire t_entry    i_left,
    input  wire logic      i_left_go,
    input  wire t_entry    i_right,
    input  wire logic      i_occupied,
    output t_entry         o_entry,
    output logic           o_go
);

    t_entry r_entry;
    t_entry n_entry;

    // slot moves aside when empty or holding a strictly later time
    assign o_go    = !i_occupied || (r_entry.ev_time > i_new.ev_time);
    assign o_entry = r_entry;

    // insert shifts right from the insertion point, remove shifts left
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_insert) begin
            if (o_go && i_left_go) begin
                n_entry = i_left;
            end else if (o_go) begin
                n_entry = i_new;
            end
        end else if (i_ctl.do_remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/stable_time_ordered_event_queue_unit.sv -----
// top level of the stable time-ordered event queue
`default_nettype none

// Sorted event queue built as a row of CAPACITY cells, slot 0 holding the
// earliest event; events with equal times leave in arrival order. Each
// request (insert or remove) gives one result in the cycle after its transfer.
// Every cell compares its stored time with the new one in parallel and the
// whole row shifts at once, so one request is taken per cycle for
// as long as results are taken; the single output register sets that
// figure, and a stalled result holds off the next request. Slot contents
// need no clearing after reset: only slots below the fill count are read.
module stable_time_ordered_event_queue_unit
    import steq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out          r_out;
    t_out          n_out;

    logic          w_accept;
    t_cell_ctl     w_ctl;
    t_entry        w_new;
    t_entry        w_entry [CAPACITY];
    logic          w_go    [CAPACITY];
    logic          w_occ   [CAPACITY];
    logic [CW+4:0] w_count_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // decode the request against the fill count
    always_comb begin
        w_ctl.do_insert = w_accept && (i_in_data.mode == MODE_INSERT)
                          && (r_count < CAP_COUNT);
        w_ctl.do_remove = w_accept && (i_in_data.mode == MODE_REMOVE)
                          && (r_count != '0);
    end

    assign w_new.ev_time   = i_in_data.event_time;
    assign w_new.ev_kind   = i_in_data.event_kind;
    assign w_new.ev_first  = i_in_data.first_datum;
    assign w_new.ev_second = i_in_data.second_datum;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_entry w_left;
        logic   w_left_go;
        t_entry w_right;

        assign w_occ[i] = CW'(i) < r_count;

        if (i == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_go = 1'b0;
        end else begin : g_body
            assign w_left    = w_entry[i-1];
            assign w_left_go = w_go[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[i];
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        steq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_left_go  (w_left_go),
            .i_right    (w_right),
            .i_occupied (w_occ[i]),
            .o_entry    (w_entry[i]),
            .o_go       (w_go[i])
        );
    end

    // next fill count
    always_comb begin
        n_count = r_count;
        if (w_ctl.do_insert) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_ext = {5'b0, n_count};

    // result of the accepted request
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_accept) begin
            n_out_valid     = 1'b1;
            n_out.out_time  = '0;
            n_out.out_kind  = '0;
            n_out.out_first = '0;
            n_out.out_second = '0;
            if (i_in_data.mode == MODE_INSERT) begin
                n_out.status = w_ctl.do_insert ? ST_OK : ST_FULL;
            end else if (w_ctl.do_remove) begin
                n_out.status     = ST_OK;
                n_out.out_time   = w_entry[0].ev_time;
                n_out.out_kind   = w_entry[0].ev_kind;
                n_out.out_first  = w_entry[0].ev_first;
                n_out.out_second = w_entry[0].ev_second;
            end else begin
                n_out.status = ST_EMPTY;
            end
            n_out.is_empty  = (n_count == '0);
            n_out.occupancy = w_count_ext[4:0];
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/steq_checker.sv -----
// port-level checks of the event queue and their binding
`default_nettype none

`include "assert_macros.svh"

module steq_checker
    import steq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

    logic w_in_xfer;
    logic w_out_stall;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;

    // a stalled result holds until its transfer
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_out_data))

    // every input transfer yields a result in the next cycle
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_in_xfer, o_out_valid)

    // empty flag agrees with the count
    `ASSERT_IMPLY(a_empty_flag, i_clk, i_rst_n, o_out_valid,
                  o_out_data.is_empty == (o_out_data.occupancy == 5'd0))

    // a rejected insert only happens at capacity
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n,
                  o_out_valid && (o_out_data.status == ST_FULL),
                  o_out_data.occupancy == CAP_LOW)

    // a remove from empty reports an empty queue and no event
    `ASSERT_IMPLY(a_empty_remove, i_clk, i_rst_n,
                  o_out_valid && (o_out_data.status == ST_EMPTY),
                  o_out_data.is_empty && (o_out_data.out_time == 32'd0))

endmodule

bind stable_time_ordered_event_queue_unit steq_checker #(
    .CAPACITY (CAPACITY)
) u_steq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
